FILE: sv/vertex_fog_alpha_unit_top_macros.svh
// Assertion macros for the vertex fog alpha unit RTL.
`ifndef VERTEX_FOG_ALPHA_UNIT_TOP_MACROS_SVH
`define VERTEX_FOG_ALPHA_UNIT_TOP_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define VFA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex fog alpha unit: check failed");

// Checks the consequent in the cycle after the antecedent.
`define VFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertex fog alpha unit: check failed");

`endif

FILE: sv/vfa_pkg.sv
// Shared types, constants and register codes of the vertex fog alpha unit.
`timescale 1ns / 1ps
`default_nettype none
package vfa_pkg;

  // Field widths.
  localparam int FuncW  = 2;
  localparam int DepthW = 16;
  localparam int ScaleW = 24;
  localparam int AlphaW = 8;

  // Configuration port widths.
  localparam int PaddrW = 5;
  localparam int PdataW = 32;

  // Pipeline depth and datapath widths.
  localparam int NumStages = 4;
  localparam int ProdW     = DepthW + ScaleW;     // dz * scale, Q8.32
  localparam int FogW      = ProdW - 16 + 1;      // rounded fog term, Q9.16
  localparam int FadeW     = ProdW + AlphaW;      // dz * scale * diffuse
  localparam int SqW       = 2 * FogW;            // fog term squared
  localparam int SqKeepW   = 40;                  // above this, 255*f*f is far past 255
  localparam int RampW     = SqKeepW + AlphaW;    // 255 * f * f

  // Rounding offsets and saturation value.
  localparam logic [ProdW:0] HalfQ16 = (ProdW + 1)'(32768);
  localparam logic [FadeW:0] HalfQ32 = (FadeW + 1)'(64'h8000_0000);
  localparam logic [RampW:0] HalfR32 = (RampW + 1)'(64'h8000_0000);
  localparam logic [AlphaW-1:0] AlphaMax = 8'd255;

  // Register reset values.
  localparam logic [ScaleW-1:0] ScaleReset = 24'h01_0000;

  // Mode codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_EXTRA = 2'd0,
    FUNC_SPEC  = 2'd1,
    FUNC_HOMOG = 2'd2,
    FUNC_PASS  = 2'd3
  } func_t;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_FOG_START       = 3'd0,
    REG_FOG_SCALE       = 3'd1,
    REG_FOG_START_HOMOG = 3'd2,
    REG_FOG_SCALE_HOMOG = 3'd3,
    REG_EXTRA_FOG       = 3'd4,
    REG_FAR_FADE_ENABLE = 3'd5,
    REG_FAR_FADE_START  = 3'd6,
    REG_FAR_FADE_SCALE  = 3'd7
  } reg_idx_t;

  // Register file contents seen by the datapath.
  typedef struct packed {
    logic [DepthW-1:0] fog_start;
    logic [ScaleW-1:0] fog_scale;
    logic [DepthW-1:0] fog_start_homog;
    logic [ScaleW-1:0] fog_scale_homog;
    logic [AlphaW-1:0] extra_fog;
    logic              far_fade_enable;
    logic [DepthW-1:0] far_fade_start;
    logic [ScaleW-1:0] far_fade_scale;
  } cfg_t;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/vfa_in_if.sv
// Request channel carrying one vertex into the fog alpha unit.
`timescale 1ns / 1ps
`default_nettype none
interface vfa_in_if;
  import vfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [DepthW-1:0] depth;
  logic [AlphaW-1:0] spec_alpha_in;
  logic [AlphaW-1:0] diffuse_alpha_in;

  modport source (output valid, func, depth, spec_alpha_in, diffuse_alpha_in, input ready);
  modport sink (input valid, func, depth, spec_alpha_in, diffuse_alpha_in, output ready);
endinterface
`default_nettype wire

FILE: sv/vfa_out_if.sv
// Request channel carrying one fogged vertex alpha pair out of the unit.
`timescale 1ns / 1ps
`default_nettype none
interface vfa_out_if;
  import vfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [AlphaW-1:0] spec_alpha_out;
  logic [AlphaW-1:0] diffuse_alpha_out;

  modport source (output valid, spec_alpha_out, diffuse_alpha_out, input ready);
  modport sink (input valid, spec_alpha_out, diffuse_alpha_out, output ready);
endinterface
`default_nettype wire

FILE: sv/vfa_cfg.sv
// APB-style configuration register file of the vertex fog alpha unit.
`timescale 1ns / 1ps
`default_nettype none
module vfa_cfg
  import vfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     regs;
  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg    = regs;

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fog_start       <= '0;
      regs.fog_scale       <= ScaleReset;
      regs.fog_start_homog <= '0;
      regs.fog_scale_homog <= ScaleReset;
      regs.extra_fog       <= '0;
      regs.far_fade_enable <= 1'b0;
      regs.far_fade_start  <= '0;
      regs.far_fade_scale  <= ScaleReset;
    end else if (wr) begin
      case (idx)
        REG_FOG_START:       regs.fog_start       <= pwdata[DepthW-1:0];
        REG_FOG_SCALE:       regs.fog_scale       <= pwdata[ScaleW-1:0];
        REG_FOG_START_HOMOG: regs.fog_start_homog <= pwdata[DepthW-1:0];
        REG_FOG_SCALE_HOMOG: regs.fog_scale_homog <= pwdata[ScaleW-1:0];
        REG_EXTRA_FOG:       regs.extra_fog       <= pwdata[AlphaW-1:0];
        REG_FAR_FADE_ENABLE: regs.far_fade_enable <= pwdata[0];
        REG_FAR_FADE_START:  regs.far_fade_start  <= pwdata[DepthW-1:0];
        REG_FAR_FADE_SCALE:  regs.far_fade_scale  <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux, zero extended.
  always_comb begin
    case (idx)
      REG_FOG_START:       prdata = PdataW'(regs.fog_start);
      REG_FOG_SCALE:       prdata = PdataW'(regs.fog_scale);
      REG_FOG_START_HOMOG: prdata = PdataW'(regs.fog_start_homog);
      REG_FOG_SCALE_HOMOG: prdata = PdataW'(regs.fog_scale_homog);
      REG_EXTRA_FOG:       prdata = PdataW'(regs.extra_fog);
      REG_FAR_FADE_ENABLE: prdata = PdataW'(regs.far_fade_enable);
      REG_FAR_FADE_START:  prdata = PdataW'(regs.far_fade_start);
      REG_FAR_FADE_SCALE:  prdata = PdataW'(regs.far_fade_scale);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/vfa_ctrl.sv
// Valid and stall control of the vertex fog alpha pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_fog_alpha_unit_top_macros.svh"
module vfa_ctrl
  import vfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output pipe_ctrl_t ctrl
);

  logic [NumStages-1:0] stage_valid;
  logic [NumStages-1:0] stage_valid_next;
  logic [NumStages-1:0] stage_ready;

  // A stage can load when it is empty or its contents move on.
  always_comb begin
    stage_ready[NumStages-1] = !stage_valid[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  // Valid bits follow the data into each loading stage.
  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (stage_ready[k]) begin
        stage_valid_next[k] = (k == 0) ? in_valid : stage_valid[(k == 0) ? 0 : k - 1];
      end else begin
        stage_valid_next[k] = stage_valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign in_ready  = stage_ready[0];
  assign out_valid = stage_valid[NumStages-1];
  assign ctrl.en   = stage_ready;

  // Input is refused only when every stage holds a request.
  `VFA_ASSERT_SAME(a_full_when_blocked, !stage_ready[0], &stage_valid)
  // An accepted request lands in the first stage.
  `VFA_ASSERT_NEXT(a_accept_enters, in_valid && stage_ready[0], stage_valid[0])
  // Requests in flight change only by acceptance and delivery.
  `VFA_ASSERT_NEXT(a_count_kept, 1'b1, $countones(stage_valid) == $past($countones(stage_valid)) + int'($past(in_valid && stage_ready[0])) - int'($past(out_valid && out_ready)))

endmodule
`default_nettype wire

FILE: sv/vfa_dpath.sv
// Four-stage fog and far fade datapath of the vertex fog alpha unit.
`timescale 1ns / 1ps
`default_nettype none
module vfa_dpath
  import vfa_pkg::*;
(
  input  logic              clk,
  input  cfg_t              cfg,
  input  pipe_ctrl_t        ctrl,
  input  logic [FuncW-1:0]  func,
  input  logic [DepthW-1:0] depth,
  input  logic [AlphaW-1:0] spec_alpha_in,
  input  logic [AlphaW-1:0] diffuse_alpha_in,
  output logic [AlphaW-1:0] spec_alpha_out,
  output logic [AlphaW-1:0] diffuse_alpha_out
);

  // Stage 1 inputs.
  func_t             in_func;
  logic [DepthW-1:0] start_c;
  logic [ScaleW-1:0] scale_c;
  logic [DepthW-1:0] dz_c;
  logic [DepthW-1:0] fdz_c;
  logic              fog_act_c;
  logic              fade_act_c;
  logic [AlphaW-1:0] sub_c;

  // Stage 1 registers.
  logic [ProdW-1:0]  s1_fog_prod;
  logic [ProdW-1:0]  s1_fade_prod;
  func_t             s1_func;
  logic              s1_fog_act;
  logic              s1_fade_act;
  logic [AlphaW-1:0] s1_spec;
  logic [AlphaW-1:0] s1_sub;
  logic [AlphaW-1:0] s1_diff;

  // Stage 2 registers.
  logic [ProdW:0]    f_sum;
  logic [FogW-1:0]   s2_f;
  logic [FadeW-1:0]  s2_fade_prod;
  func_t             s2_func;
  logic              s2_fog_act;
  logic              s2_fade_act;
  logic [AlphaW-1:0] s2_spec;
  logic [AlphaW-1:0] s2_sub;
  logic [AlphaW-1:0] s2_diff;

  // Stage 3 registers.
  logic [FadeW:0]    fa_sum;
  logic [16:0]       fa;
  logic [AlphaW-1:0] diff_c;
  logic [SqW-1:0]    s3_sq;
  func_t             s3_func;
  logic              s3_fog_act;
  logic [AlphaW-1:0] s3_spec;
  logic [AlphaW-1:0] s3_sub;
  logic [AlphaW-1:0] s3_diff;

  // Stage 4 logic.
  logic              big;
  logic [RampW-1:0]  ramp;
  logic [RampW:0]    r_sum;
  logic [16:0]       r;
  logic [AlphaW-1:0] fv;
  logic [AlphaW-1:0] spec_c;

  // Stage 1: pick the fog range by mode and form both depth products.
  always_comb begin
    in_func    = func_t'(func);
    start_c    = (in_func == FUNC_HOMOG) ? cfg.fog_start_homog : cfg.fog_start;
    scale_c    = (in_func == FUNC_HOMOG) ? cfg.fog_scale_homog : cfg.fog_scale;
    fog_act_c  = depth > start_c;
    dz_c       = depth - start_c;
    fdz_c      = depth - cfg.far_fade_start;
    fade_act_c = cfg.far_fade_enable && (depth > cfg.far_fade_start) &&
                 (in_func == FUNC_EXTRA || in_func == FUNC_SPEC);
    sub_c      = (in_func == FUNC_EXTRA) ? cfg.extra_fog : spec_alpha_in;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      s1_fog_prod  <= ProdW'(dz_c) * ProdW'(scale_c);
      s1_fade_prod <= ProdW'(fdz_c) * ProdW'(cfg.far_fade_scale);
      s1_func      <= in_func;
      s1_fog_act   <= fog_act_c;
      s1_fade_act  <= fade_act_c;
      s1_spec      <= spec_alpha_in;
      s1_sub       <= sub_c;
      s1_diff      <= diffuse_alpha_in;
    end
  end

  // Stage 2: round the fog term to Q9.16 and scale the fade by diffuse.
  assign f_sum = {1'b0, s1_fog_prod} + HalfQ16;

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      s2_f         <= f_sum[ProdW:16];
      s2_fade_prod <= FadeW'(s1_fade_prod) * FadeW'(s1_diff);
      s2_func      <= s1_func;
      s2_fog_act   <= s1_fog_act;
      s2_fade_act  <= s1_fade_act;
      s2_spec      <= s1_spec;
      s2_sub       <= s1_sub;
      s2_diff      <= s1_diff;
    end
  end

  // Stage 3: square the fog term and finish the saturating far fade.
  always_comb begin
    fa_sum = {1'b0, s2_fade_prod} + HalfQ32;
    fa     = fa_sum[FadeW:32];
    if (!s2_fade_act) begin
      diff_c = s2_diff;
    end else if (fa >= 17'(s2_diff)) begin
      diff_c = '0;
    end else begin
      diff_c = s2_diff - fa[AlphaW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      s3_sq      <= SqW'(s2_f) * SqW'(s2_f);
      s3_func    <= s2_func;
      s3_fog_act <= s2_fog_act;
      s3_spec    <= s2_spec;
      s3_sub     <= s2_sub;
      s3_diff    <= diff_c;
    end
  end

  // Stage 4: 255 - round(255*f*f), then the per-mode subtraction or pass-through.
  always_comb begin
    big   = |s3_sq[SqW-1:SqKeepW];
    ramp  = {s3_sq[SqKeepW-1:0], 8'd0} - {8'd0, s3_sq[SqKeepW-1:0]};
    r_sum = {1'b0, ramp} + HalfR32;
    r     = r_sum[RampW:32];
    if (!s3_fog_act) begin
      fv = AlphaMax;
    end else if (big || r >= 17'(AlphaMax)) begin
      fv = '0;
    end else begin
      fv = AlphaMax - r[AlphaW-1:0];
    end
    case (s3_func)
      FUNC_EXTRA, FUNC_SPEC: spec_c = (fv > s3_sub) ? fv - s3_sub : '0;
      FUNC_HOMOG:            spec_c = s3_fog_act ? fv : s3_spec;
      default:               spec_c = s3_spec;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      spec_alpha_out    <= spec_c;
      diffuse_alpha_out <= s3_diff;
    end
  end

endmodule
`default_nettype wire

FILE: sv/vertex_fog_alpha_unit_top.sv
// Top level of the per-vertex quadratic depth fog and far alpha fade unit.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// A vertex request (mode, depth, specular alpha, diffuse alpha) enters on in_ch
// and its fog alpha and faded diffuse alpha leave on out_ch; a request moves
// when valid and ready are both high. Fog and fade settings are written over
// the APB-style port, one register per 4-byte word; the user must write them
// only while no request is in flight, which the block itself does not enforce;
// pready is always high and reads return the stored values. A request passes
// through four register stages that hold the depth products, the rounded fog
// term with the fade product, the squared fog term with the finished fade, and
// the output register.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the output holds and empty stages still fill, so
// in_ch.ready falls only once all four stages are occupied; nothing is lost.
// Reset (rst, synchronous) empties the pipeline and restores the register
// defaults: starts 0, scales 1.0, extra fog 0, far fade off.
module vertex_fog_alpha_unit_top
  import vfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  vfa_in_if.sink            in_ch,
  vfa_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  // Configuration registers.
  vfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage valids and stall handling.
  vfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  // Fog and fade arithmetic.
  vfa_dpath u_dpath (
    .clk               (clk),
    .cfg               (cfg),
    .ctrl              (ctrl),
    .func              (in_ch.func),
    .depth             (in_ch.depth),
    .spec_alpha_in     (in_ch.spec_alpha_in),
    .diffuse_alpha_in  (in_ch.diffuse_alpha_in),
    .spec_alpha_out    (out_ch.spec_alpha_out),
    .diffuse_alpha_out (out_ch.diffuse_alpha_out)
  );

endmodule
`default_nettype wire
